@@ src/ccp_pkg.sv @@
// Shared types, widths and helpers for the circle-circle proximity block.
// No dependencies; every other file in src/ imports this package.
package ccp_pkg;

    localparam int CW    = 32;          // coordinate width
    localparam int RW    = CW - 1;      // radius width
    localparam int DW    = CW + 1;      // center difference / magnitude width
    localparam int SQW   = 2 * DW;      // sum of squares width
    localparam int ROOTW = DW;          // square root width
    localparam int QW    = RW;          // quotient width (offset <= radius)
    localparam int NW    = RW + DW;     // radius * magnitude width
    localparam int ML    = (DW + 1) / 2;
    localparam int MH    = DW - ML;
    localparam int GW    = DW + 2;      // pre-saturation width
    localparam int LAT_SQ = ROOTW + 1;
    localparam int LAT_DV = QW + 2;

    typedef enum logic [0:0] {
        REG_RADIUS_A = 1'b0,
        REG_RADIUS_B = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic signed [CW-1:0] first_x;
        logic signed [CW-1:0] first_y;
        logic signed [CW-1:0] second_x;
        logic signed [CW-1:0] second_y;
        logic                 first_is_a;
    } t_in;

    typedef struct packed {
        logic signed [CW-1:0] gap;
        logic signed [CW-1:0] near1_x;
        logic signed [CW-1:0] near1_y;
        logic signed [CW-1:0] near2_x;
        logic signed [CW-1:0] near2_y;
        logic                 coincident;
        logic                 clipped;
    } t_out;

    // context carried alongside the arithmetic
    typedef struct packed {
        logic [CW-1:0]    x1;
        logic [CW-1:0]    y1;
        logic [CW-1:0]    x2;
        logic [CW-1:0]    y2;
        logic [RW-1:0]    r1;
        logic [RW-1:0]    r2;
        logic [DW-1:0]    ax;
        logic [DW-1:0]    ay;
        logic             sx;
        logic             sy;
        logic [ROOTW-1:0] cdist;
    } t_ctx;

    function automatic logic sat_clip(input logic [GW-1:0] v);
        return !((&v[GW-1:CW-1]) || !(|v[GW-1:CW-1]));
    endfunction

    function automatic logic [CW-1:0] sat_val(input logic [GW-1:0] v);
        if (sat_clip(v)) begin
            return v[GW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
        return v[CW-1:0];
    endfunction

    // x + (neg ? -q : q), wide enough to never wrap
    function automatic logic [GW-1:0] add_off(input logic [CW-1:0] x,
                                              input logic [QW-1:0] q,
                                              input logic neg);
        logic [GW-1:0] xe;
        logic [GW-1:0] qe;
        xe = {{(GW-CW){x[CW-1]}}, x};
        qe = {{(GW-QW){1'b0}}, q};
        return neg ? (xe - qe) : (xe + qe);
    endfunction

endpackage

@@ src/ccp_sqrt.sv @@
// Pipelined integer square root, one root bit per stage.
// Depends on ccp_pkg.
module ccp_sqrt (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [ccp_pkg::SQW-1:0]     i_val,
    output logic [ccp_pkg::ROOTW-1:0]   o_root
);
    import ccp_pkg::*;

    logic [SQW-1:0]   r_rem  [0:ROOTW];
    logic [ROOTW-1:0] r_root [0:ROOTW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_val;
            r_root[0] <= '0;
        end
    end

    for (genvar k = 0; k < ROOTW; k++) begin : g_stage
        localparam int B = ROOTW - 1 - k;
        logic [SQW-1:0]   trial;
        logic [SQW-1:0]   n_rem;
        logic [ROOTW-1:0] n_root;

        always_comb begin
            // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
            trial  = (SQW'(r_root[k]) << (B + 1)) | (SQW'(1) << (2 * B));
            n_rem  = r_rem[k];
            n_root = r_root[k];
            if (r_rem[k] >= trial) begin
                n_rem     = r_rem[k] - trial;
                n_root[B] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= n_rem;
                r_root[k+1] <= n_root;
            end
        end
    end

    assign o_root = r_root[ROOTW];

endmodule

@@ src/ccp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, round to nearest.
// Depends on ccp_pkg. Quotient is known to fit in QW bits.
module ccp_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [ccp_pkg::NW-1:0]      i_num,
    input  logic [ccp_pkg::DW-1:0]      i_den,
    output logic [ccp_pkg::QW-1:0]      o_quo
);
    import ccp_pkg::*;

    logic [NW-1:0] r_rem [0:QW];
    logic [DW-1:0] r_den [0:QW];
    logic [QW-1:0] r_quo [0:QW];
    logic [QW-1:0] r_out;
    logic          n_half;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_quo[0] <= '0;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int B = QW - 1 - k;
        logic [NW-1:0] trial;
        logic [NW-1:0] n_rem;
        logic [QW-1:0] n_quo;

        always_comb begin
            trial = NW'(r_den[k]) << B;
            n_rem = r_rem[k];
            n_quo = r_quo[k];
            if (r_rem[k] >= trial) begin
                n_rem    = r_rem[k] - trial;
                n_quo[B] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= n_rem;
                r_den[k+1] <= r_den[k];
                r_quo[k+1] <= n_quo;
            end
        end
    end

    // ties round up: rem >= den - rem
    assign n_half = r_rem[QW] >= (NW'(r_den[QW]) - r_rem[QW]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= r_quo[QW] + QW'(n_half);
        end
    end

    assign o_quo = r_out;

endmodule

@@ src/circle_circle_proximity.sv @@
// Circle-circle proximity: gap and nearest points of two circles, Q16.16.
// Throughput one item per cycle, except while a result waits at the output and is not taken.
// The depth is set by the square root (34 stages) and the dividers (33 stages).
// Reset (synchronous, active low) clears both radii and empties the pipeline.
// Depends on ccp_pkg, ccp_sqrt and ccp_div.
module circle_circle_proximity (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  ccp_pkg::t_in            i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output ccp_pkg::t_out           o_out_data,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_idx,
    input  logic [ccp_pkg::RW-1:0]  i_cfg_data
);
    import ccp_pkg::*;

    // Whole pipeline moves together; it holds only when the output item
    // is waiting and not taken. The output register is the skid point.
    logic en;

    // configuration
    logic [RW-1:0] r_rad_a;
    logic [RW-1:0] r_rad_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rad_a <= '0;
            r_rad_b <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_RADIUS_A: r_rad_a <= i_cfg_data;
                REG_RADIUS_B: r_rad_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits
    logic r_va, r_vb, r_vc, r_vd, r_ve, r_vf, r_vg, r_vh, r_ov;
    logic r_vs [0:LAT_SQ-1];
    logic r_vq [0:LAT_DV-1];

    // data
    t_ctx r_ca, r_cb, r_cc, r_cd, r_ce, r_cf, r_cg, r_ch;
    t_ctx r_cs [0:LAT_SQ-1];
    t_ctx r_cq [0:LAT_DV-1];
    logic [DW-1:0]     r_dx, r_dy;
    logic [DW+ML-1:0]  r_pxl, r_pyl;
    logic [DW+MH-1:0]  r_pxh, r_pyh;
    logic [SQW-1:0]    r_sqx, r_sqy, r_sum;
    logic [RW+ML-1:0]  r_pl [0:3];
    logic [RW+MH-1:0]  r_ph [0:3];
    logic [NW-1:0]     r_num [0:3];
    logic [ROOTW-1:0]  root_dist;
    logic [QW-1:0]     quo [0:3];
    t_out              r_out;

    assign en          = !r_ov || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0; r_vb <= 1'b0; r_vc <= 1'b0; r_vd <= 1'b0;
            r_ve <= 1'b0; r_vf <= 1'b0; r_vg <= 1'b0; r_vh <= 1'b0;
            r_ov <= 1'b0;
            for (int k = 0; k < LAT_SQ; k++) r_vs[k] <= 1'b0;
            for (int k = 0; k < LAT_DV; k++) r_vq[k] <= 1'b0;
        end else if (en) begin
            r_va <= i_in_valid;
            r_vb <= r_va; r_vc <= r_vb; r_vd <= r_vc;
            r_ve <= r_vd; r_vf <= r_ve;
            r_vs[0] <= r_vf;
            for (int k = 1; k < LAT_SQ; k++) r_vs[k] <= r_vs[k-1];
            r_vg <= r_vs[LAT_SQ-1];
            r_vh <= r_vg;
            r_vq[0] <= r_vh;
            for (int k = 1; k < LAT_DV; k++) r_vq[k] <= r_vq[k-1];
            r_ov <= r_vq[LAT_DV-1];
        end
    end

    // stage A: capture centers and pick radii by role
    t_ctx n_ca;
    always_comb begin
        n_ca    = '0;
        n_ca.x1 = i_in_data.first_x;
        n_ca.y1 = i_in_data.first_y;
        n_ca.x2 = i_in_data.second_x;
        n_ca.y2 = i_in_data.second_y;
        n_ca.r1 = i_in_data.first_is_a ? r_rad_a : r_rad_b;
        n_ca.r2 = i_in_data.first_is_a ? r_rad_b : r_rad_a;
    end

    // stage C: magnitudes and signs
    t_ctx n_cc;
    always_comb begin
        n_cc    = r_cb;
        n_cc.sx = r_dx[DW-1];
        n_cc.sy = r_dy[DW-1];
        n_cc.ax = r_dx[DW-1] ? (DW'(0) - r_dx) : r_dx;
        n_cc.ay = r_dy[DW-1] ? (DW'(0) - r_dy) : r_dy;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ca <= n_ca;
            // B: center differences, one bit wider than a coordinate
            r_cb <= r_ca;
            r_dx <= {r_ca.x2[CW-1], r_ca.x2} - {r_ca.x1[CW-1], r_ca.x1};
            r_dy <= {r_ca.y2[CW-1], r_ca.y2} - {r_ca.y1[CW-1], r_ca.y1};
            r_cc <= n_cc;
            // D: squares as two partial products each
            r_cd  <= r_cc;
            r_pxl <= (DW+ML)'(r_cc.ax) * (DW+ML)'(r_cc.ax[ML-1:0]);
            r_pxh <= (DW+MH)'(r_cc.ax) * (DW+MH)'(r_cc.ax[DW-1:ML]);
            r_pyl <= (DW+ML)'(r_cc.ay) * (DW+ML)'(r_cc.ay[ML-1:0]);
            r_pyh <= (DW+MH)'(r_cc.ay) * (DW+MH)'(r_cc.ay[DW-1:ML]);
            // E: recombine partials
            r_ce  <= r_cd;
            r_sqx <= SQW'(r_pxl) + (SQW'(r_pxh) << ML);
            r_sqy <= SQW'(r_pyl) + (SQW'(r_pyh) << ML);
            // F: dx^2 + dy^2
            r_cf  <= r_ce;
            r_sum <= r_sqx + r_sqy;
            // context rides alongside the square root
            r_cs[0] <= r_cf;
            for (int k = 1; k < LAT_SQ; k++) r_cs[k] <= r_cs[k-1];
        end
    end

    ccp_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (r_sum),
        .o_root (root_dist)
    );

    // stage G: radius times magnitude, split in halves of the magnitude
    t_ctx n_cg;
    always_comb begin
        n_cg       = r_cs[LAT_SQ-1];
        n_cg.cdist = root_dist;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cg    <= n_cg;
            r_pl[0] <= (RW+ML)'(n_cg.r1) * (RW+ML)'(n_cg.ax[ML-1:0]);
            r_ph[0] <= (RW+MH)'(n_cg.r1) * (RW+MH)'(n_cg.ax[DW-1:ML]);
            r_pl[1] <= (RW+ML)'(n_cg.r1) * (RW+ML)'(n_cg.ay[ML-1:0]);
            r_ph[1] <= (RW+MH)'(n_cg.r1) * (RW+MH)'(n_cg.ay[DW-1:ML]);
            r_pl[2] <= (RW+ML)'(n_cg.r2) * (RW+ML)'(n_cg.ax[ML-1:0]);
            r_ph[2] <= (RW+MH)'(n_cg.r2) * (RW+MH)'(n_cg.ax[DW-1:ML]);
            r_pl[3] <= (RW+ML)'(n_cg.r2) * (RW+ML)'(n_cg.ay[ML-1:0]);
            r_ph[3] <= (RW+MH)'(n_cg.r2) * (RW+MH)'(n_cg.ay[DW-1:ML]);
            // H: numerators
            r_ch <= r_cg;
            for (int k = 0; k < 4; k++) begin
                r_num[k] <= NW'(r_pl[k]) + (NW'(r_ph[k]) << ML);
            end
            // context rides alongside the dividers
            r_cq[0] <= r_ch;
            for (int k = 1; k < LAT_DV; k++) r_cq[k] <= r_cq[k-1];
        end
    end

    // Offsets r*|d|/dist. A zero distance feeds garbage through; the
    // result stage replaces it with the centers.
    for (genvar k = 0; k < 4; k++) begin : g_div
        ccp_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_num[k]),
            .i_den (r_ch.cdist),
            .o_quo (quo[k])
        );
    end

    // stage I: gap, points, saturation -> output register
    t_ctx          c;
    logic [GW-1:0] gap_w, n1x_w, n1y_w, n2x_w, n2y_w;
    logic          coin;
    t_out          n_out;

    always_comb begin
        c     = r_cq[LAT_DV-1];
        coin  = (c.cdist == '0);
        gap_w = GW'(c.cdist) - GW'(c.r1) - GW'(c.r2);
        n1x_w = add_off(c.x1, quo[0], c.sx);
        n1y_w = add_off(c.y1, quo[1], c.sy);
        n2x_w = add_off(c.x2, quo[2], !c.sx);
        n2y_w = add_off(c.y2, quo[3], !c.sy);

        n_out            = '0;
        n_out.gap        = sat_val(gap_w);
        n_out.coincident = coin;
        if (coin) begin
            n_out.near1_x = c.x1;
            n_out.near1_y = c.y1;
            n_out.near2_x = c.x2;
            n_out.near2_y = c.y2;
            n_out.clipped = sat_clip(gap_w);
        end else begin
            n_out.near1_x = sat_val(n1x_w);
            n_out.near1_y = sat_val(n1y_w);
            n_out.near2_x = sat_val(n2x_w);
            n_out.near2_y = sat_val(n2y_w);
            n_out.clipped = sat_clip(gap_w) || sat_clip(n1x_w) || sat_clip(n1y_w)
                         || sat_clip(n2x_w) || sat_clip(n2y_w);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for circle_circle_proximity: random and directed center pairs,
// results predicted in-bench and compared field by field. Depends on ccp_pkg and the RTL.
module tb;
    import ccp_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out_data;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [RW-1:0] i_cfg_data;

    circle_circle_proximity uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    localparam int PIPE_LAT = 75;
    localparam longint CYCLE_LIMIT = 400000;

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    // bench copy of the radius registers
    logic [RW-1:0] rad_a, rad_b;

    t_in  pending_items[$];
    t_out proximity_q[$];
    int   errors = 0;
    int   checked = 0;
    int   n_coin = 0, n_clip = 0;
    longint cycles = 0;
    bit   long_hold = 0;    // receiver holds off while set
    bit   send_pause = 0;
    bit   in_acc = 0;       // item taken at the last rising edge

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch item %0d %s: got %h want %h", checked, what, got, want);
        errors++;
    endtask

    // round(n/d), ties up; n up to ~2^64, d nonzero
    function automatic logic [QW-1:0] scaled_offset(input logic [RW-1:0] r,
                                                    input logic [DW-1:0] m,
                                                    input logic [ROOTW-1:0] cdist);
        logic [127:0] n, q, rem;
        n = 128'(r) * 128'(m);
        q = n / 128'(cdist);
        rem = n % 128'(cdist);
        if (rem >= 128'(cdist) - rem) q++;
        return q[QW-1:0];
    endfunction

    function automatic logic [ROOTW-1:0] floor_root(input logic [127:0] v);
        logic [127:0] r, c;
        r = 0;
        for (int b = 51; b >= 0; b--) begin
            c = r | (128'd1 << b);
            if (c * c <= v) r = c;
        end
        return r[ROOTW-1:0];
    endfunction

    function automatic logic signed [31:0] clamp(input logic signed [63:0] v, inout logic clip);
        if (v > 64'sd2147483647) begin clip = 1; return 32'sh7fffffff; end
        if (v < -64'sd2147483648) begin clip = 1; return 32'sh80000000; end
        return v[31:0];
    endfunction

    function automatic t_out predict_proximity(input t_in it);
        t_out o;
        logic signed [63:0] x1, y1, x2, y2, dx, dy, ox, oy;
        logic [63:0] ax, ay;
        logic [RW-1:0] r1, r2;
        logic [ROOTW-1:0] cdist;
        logic clip;
        x1 = it.first_x; y1 = it.first_y; x2 = it.second_x; y2 = it.second_y;
        r1 = it.first_is_a ? rad_a : rad_b;
        r2 = it.first_is_a ? rad_b : rad_a;
        dx = x2 - x1; dy = y2 - y1;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        cdist = floor_root(128'(ax) * 128'(ax) + 128'(ay) * 128'(ay));
        clip = 0;
        o.gap = clamp(64'(cdist) - 64'(r1) - 64'(r2), clip);
        o.coincident = (dx == 0 && dy == 0);
        if (o.coincident) begin
            o.near1_x = x1[31:0]; o.near1_y = y1[31:0];
            o.near2_x = x2[31:0]; o.near2_y = y2[31:0];
        end else begin
            ox = 64'(scaled_offset(r1, ax[DW-1:0], cdist));
            oy = 64'(scaled_offset(r1, ay[DW-1:0], cdist));
            o.near1_x = clamp(dx < 0 ? x1 - ox : x1 + ox, clip);
            o.near1_y = clamp(dy < 0 ? y1 - oy : y1 + oy, clip);
            ox = 64'(scaled_offset(r2, ax[DW-1:0], cdist));
            oy = 64'(scaled_offset(r2, ay[DW-1:0], cdist));
            o.near2_x = clamp(dx < 0 ? x2 + ox : x2 - ox, clip);
            o.near2_y = clamp(dy < 0 ? y2 + oy : y2 - oy, clip);
        end
        o.clipped = clip;
        return o;
    endfunction

    // driver: one item at a time from pending_items, random gap between items
    int send_wait = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_acc) begin
            // hold item
        end else if (send_wait > 0) begin
            send_wait <= send_wait - 1;
            i_in_valid <= 1'b0;
        end else if (pending_items.size() > 0 && !send_pause) begin
            i_in_data  <= pending_items.pop_front();
            i_in_valid <= 1'b1;
            send_wait  <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // acceptance: predict at the edge where the item is taken
    always @(posedge i_clk) begin
        in_acc <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready)
            proximity_q.push_back(predict_proximity(i_in_data));
    end

    // monitor with random receiver stalls
    int recv_wait = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n || long_hold) begin
            i_out_ready <= 1'b0;
        end else if (recv_wait > 0) begin
            recv_wait <= recv_wait - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (o_out_valid) recv_wait <= $urandom_range(0, 4);
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", proximity_q.size());
            $display("TB_ERROR");
            $finish;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (proximity_q.size() == 0) begin
                report("unexpected item", 0, 0);
            end else begin
                want = proximity_q.pop_front();
                if (o_out_data.gap !== want.gap) report("gap", o_out_data.gap, want.gap);
                if (o_out_data.near1_x !== want.near1_x)
                    report("near1_x", o_out_data.near1_x, want.near1_x);
                if (o_out_data.near1_y !== want.near1_y)
                    report("near1_y", o_out_data.near1_y, want.near1_y);
                if (o_out_data.near2_x !== want.near2_x)
                    report("near2_x", o_out_data.near2_x, want.near2_x);
                if (o_out_data.near2_y !== want.near2_y)
                    report("near2_y", o_out_data.near2_y, want.near2_y);
                if (o_out_data.coincident !== want.coincident)
                    report("coincident", o_out_data.coincident, want.coincident);
                if (o_out_data.clipped !== want.clipped)
                    report("clipped", o_out_data.clipped, want.clipped);
                n_coin += want.coincident;
                n_clip += want.clipped;
                checked++;
            end
        end
    end

    task automatic write_radius(input t_reg_idx idx, input logic [RW-1:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= v;
        if (idx == REG_RADIUS_A) rad_a = v; else rad_b = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || proximity_q.size() > 0 || i_in_valid)
            @(posedge i_clk);
        repeat (PIPE_LAT + 5) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            2: return 32'($signed($urandom_range(0, 2000)) - 1000);
            default: return 32'($signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000);
        endcase
    endfunction

    task automatic queue_item(input logic [31:0] ax_, ay_, bx, by, input logic fa);
        t_in it;
        it.first_x = ax_; it.first_y = ay_; it.second_x = bx; it.second_y = by;
        it.first_is_a = fa;
        pending_items.push_back(it);
    endtask

    task automatic queue_random(input int n);
        logic [31:0] x, y;
        for (int k = 0; k < n; k++) begin
            x = pick_coord(); y = pick_coord();
            if ($urandom_range(0, 19) == 0) queue_item(x, y, x, y, $urandom_range(0, 1));
            else queue_item(x, y, pick_coord(), pick_coord(), $urandom_range(0, 1));
        end
    endtask

    logic [RW-1:0] rad_set[5];

    initial begin
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_out_ready = 1'b0;
        i_in_data = '0; i_cfg_we = 1'b0; i_cfg_idx = REG_RADIUS_A; i_cfg_data = '0;
        rad_a = '0; rad_b = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        // directed: zero radii after reset, then extremes
        queue_item(0, 0, 0, 0, 0);
        queue_item(32'h00010000, 0, 0, 0, 1);
        drain();
        write_radius(REG_RADIUS_A, {RW{1'b1}});
        write_radius(REG_RADIUS_B, 31'h00020000);
        queue_item(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 1);
        queue_item(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 0);
        queue_item(32'h80000000, 0, 32'h7fffffff, 0, 1);
        queue_item(0, 32'h7fffffff, 0, 32'h80000000, 0);
        queue_item(32'h12345678, 32'h9abcdef0, 32'h12345678, 32'h9abcdef0, 1);
        queue_item(32'h7fffffff, 0, 32'h7fffffff, 0, 0);
        queue_item(0, 0, 3, 4, 1);
        queue_item(0, 0, -3, -4, 0);
        queue_item(0, 0, 1, 1, 1);
        queue_item(32'hffffffff, 32'hffffffff, 32'h00000001, 32'h00000001, 0);
        drain();
        write_radius(REG_RADIUS_A, 31'h3);
        write_radius(REG_RADIUS_B, 31'h0);
        queue_item(0, 0, 2, 0, 1);     // small radii, short center distances
        queue_item(0, 0, -2, 0, 0);
        queue_item(0, 0, 7, 5, 1);
        queue_item(5, 5, 5, 6, 0);
        drain();

        rad_set = '{31'h0, {RW{1'b1}}, 31'h00010000, 31'h00800000, 31'h40000000};
        for (int ph = 0; ph < 6; ph++) begin
            write_radius(REG_RADIUS_A, ph < 5 ? rad_set[ph] : 31'($urandom));
            write_radius(REG_RADIUS_B, ph < 5 ? rad_set[4 - ph] : 31'($urandom));
            queue_random(180);
            if (ph == 2) begin
                // long receiver stall so the pipeline fills and stalls the input
                long_hold = 1;
                repeat (300) @(posedge i_clk);
                long_hold = 0;
            end
            if (ph == 4) begin
                // sender holds off until all outstanding results are back
                repeat (40) @(posedge i_clk);
                send_pause = 1;
                while (proximity_q.size() > 0) @(posedge i_clk);
                send_pause = 0;
            end
            drain();
        end

        $display("checked %0d results over 9 radius settings", checked);
        $display("coincident centers %0d, saturated results %0d", n_coin, n_clip);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

@@ sim.f @@
src/ccp_pkg.sv
src/ccp_sqrt.sv
src/ccp_div.sv
src/circle_circle_proximity.sv
verif/tb.sv
